### rtl/phrs_pkg.sv
package phrs_pkg;

    localparam int HistDepth = 64;
    localparam int HistAw    = $clog2(HistDepth);
    localparam int PriceW    = 32;
    localparam int RetW      = 32;
    localparam int VolW      = 31;
    localparam int WinW      = 7;
    localparam int LossW     = 31;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 32;
    localparam int DivW      = 72;
    localparam int CntW      = 7;

    localparam logic [CntW-1:0] DivLast  = CntW'(DivW - 1);
    localparam logic [CntW-1:0] SqrtLast = CntW'(31);

    typedef enum logic [CfgIdxW-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_RETURN_SCALE  = 2'd1,
        REG_RETURN_OFFSET = 2'd2,
        REG_LOSS_WEIGHT   = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RET_DIV,
        S_RET_FIN,
        S_SUM_RD,
        S_SUM_ACC,
        S_MEAN_LD,
        S_MEAN_DIV,
        S_MEAN_FIN,
        S_VAR_RD,
        S_VAR_MUL,
        S_VAR_ACC,
        S_VAR_LD,
        S_VAR_DIV,
        S_VAR_FIN,
        S_SQRT,
        S_UTIL_RD,
        S_UTIL_MUL,
        S_UTIL_T,
        S_UTIL_LW,
        S_UTIL_LWF,
        S_UTIL_ACC,
        S_UTIL_LD,
        S_UTIL_DIV,
        S_UTIL_FIN,
        S_DONE
    } t_state;

endpackage

### rtl/phrs_in_if.sv
interface phrs_in_if;
    logic                           valid;
    logic                           ready;
    logic [phrs_pkg::PriceW-1:0]    price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

### rtl/phrs_out_if.sv
interface phrs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [phrs_pkg::RetW-1:0]   newest_return;
    logic signed [phrs_pkg::RetW-1:0]   mean_return;
    logic [phrs_pkg::VolW-1:0]          volatility;
    logic signed [phrs_pkg::RetW-1:0]   utility;
    logic                               zero_price_flag;

    modport source (output valid, output newest_return, output mean_return,
                    output volatility, output utility, output zero_price_flag,
                    input ready);
    modport sink   (input valid, input newest_return, input mean_return,
                    input volatility, input utility, input zero_price_flag,
                    output ready);
endinterface

### rtl/price_history_return_statistics.sv
// sequence: return division, sum walk, mean division, variance walk and division, root,
// utility walk and division; a walk covers n = window entries, reset 20, clamped to 64
// a new word is taken only in idle, once the last result is loaded for output;
// the 1-bit/cycle divider serves four divisions, the one-read-port memory three walks
// reset: synchronous active low; clears config to defaults, write position,
// last price and the per-entry valid bits (an unwritten entry reads as zero)
module price_history_return_statistics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [phrs_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [phrs_pkg::CfgDataW-1:0]       i_cfg_data,
    phrs_in_if.sink                             i_price_ch,
    phrs_out_if.source                          o_result_ch
);

    // state
    phrs_pkg::t_state r_state, n_state;

    // config registers
    logic [phrs_pkg::WinW-1:0]      r_wl;
    logic signed [31:0]             r_scale;
    logic signed [31:0]             r_offset;
    logic [phrs_pkg::LossW-1:0]     r_lw;

    // history: last price in a register, returns in a memory with valid bits
    logic [phrs_pkg::PriceW-1:0]    r_prev;
    logic [phrs_pkg::PriceW-1:0]    r_price;
    logic [phrs_pkg::HistAw-1:0]    r_wp;
    logic [31:0]                    r_mem [phrs_pkg::HistDepth];
    logic [phrs_pkg::HistDepth-1:0] r_vld;
    logic [31:0]                    r_rd_data;
    logic                           r_rd_ok;
    logic signed [31:0]             rd_ret;
    logic [phrs_pkg::HistAw-1:0]    rd_addr;

    // sequencer counter and window size
    logic [phrs_pkg::CntW-1:0]      r_cnt;
    logic [phrs_pkg::WinW-1:0]      win_n;
    logic                           last_elem;

    // shared restoring divider, one quotient bit per cycle
    logic [phrs_pkg::DivW-1:0]      r_dvd;
    logic [32:0]                    r_rem;
    logic [31:0]                    r_dsr;
    logic [32:0]                    div_sh;
    logic                           div_ge;
    logic                           r_neg;

    // shared multiplier
    logic signed [35:0]             mul_a;
    logic signed [32:0]             mul_b;
    logic signed [68:0]             r_prod;

    // accumulators and intermediate results
    logic signed [37:0]             r_sum;
    logic [70:0]                    r_sumsq;
    logic signed [47:0]             r_usum;
    logic signed [40:0]             r_term;
    logic signed [35:0]             r_t;
    logic signed [31:0]             r_ret;
    logic                           r_flag;
    logic signed [31:0]             r_mean;
    logic [30:0]                    r_vol;
    logic signed [31:0]             r_util;

    // square root unit
    logic [63:0]                    r_sv;
    logic [33:0]                    r_srem;
    logic [31:0]                    r_root;
    logic [35:0]                    sq_sh;
    logic [35:0]                    sq_trial;
    logic                           sq_ge;

    // output register
    logic                           r_out_valid;
    logic signed [31:0]             r_out_ret;
    logic signed [31:0]             r_out_mean;
    logic [30:0]                    r_out_vol;
    logic signed [31:0]             r_out_util;
    logic                           r_out_flag;

    logic                           in_ready;
    logic                           in_take;
    logic                           out_load;

    // combinational helpers
    logic [31:0]                    diff_mag;
    logic                           diff_neg;
    logic signed [31:0]             ret_val;
    logic signed [32:0]             dev;
    logic signed [68:0]             util_x;
    logic [37:0]                    sum_abs;
    logic [47:0]                    usum_abs;
    logic [63:0]                    var_val;

    // window clamp: 0 acts as 1, above depth acts as depth
    always_comb begin
        if (r_wl == '0) begin
            win_n = phrs_pkg::WinW'(1);
        end else if (r_wl > phrs_pkg::WinW'(phrs_pkg::HistDepth)) begin
            win_n = phrs_pkg::WinW'(phrs_pkg::HistDepth);
        end else begin
            win_n = r_wl;
        end
    end

    assign last_elem = (r_cnt == phrs_pkg::CntW'(win_n - 1'b1));
    assign rd_addr   = r_wp - r_cnt[phrs_pkg::HistAw-1:0];
    assign rd_ret    = r_rd_ok ? $signed(r_rd_data) : 32'sd0;

    assign div_sh = {r_rem[31:0], r_dvd[phrs_pkg::DivW-1]};
    assign div_ge = (div_sh >= {1'b0, r_dsr});

    assign sq_sh    = {r_srem, r_sv[63:62]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign diff_neg = (i_price_ch.price < r_prev);
    assign diff_mag = diff_neg ? (r_prev - i_price_ch.price) : (i_price_ch.price - r_prev);

    assign dev     = 33'(rd_ret) - 33'(r_mean);
    assign util_x  = r_prod + (69'(r_offset) <<< 28);
    assign sum_abs = r_sum[37] ? 38'(-r_sum) : 38'(r_sum);
    assign usum_abs = r_usum[47] ? 48'(-r_usum) : 48'(r_usum);
    assign var_val = (r_sumsq[70:64] >= win_n) ? 64'hFFFF_FFFF_FFFF_FFFF : r_dvd[63:0];

    // return from the quotient: sign, saturation, zero price
    always_comb begin
        if (r_price == '0) begin
            ret_val = r_neg ? 32'sh8000_0000 : 32'sd0;
        end else if (r_neg) begin
            ret_val = (r_dvd > 72'h8000_0000) ? 32'sh8000_0000 : 32'(-r_dvd[31:0]);
        end else begin
            ret_val = (r_dvd > 72'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_dvd[31:0]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            phrs_pkg::S_IDLE:     if (in_take) n_state = phrs_pkg::S_RET_DIV;
            phrs_pkg::S_RET_DIV:  if (r_cnt == phrs_pkg::DivLast) n_state = phrs_pkg::S_RET_FIN;
            phrs_pkg::S_RET_FIN:  n_state = phrs_pkg::S_SUM_RD;
            phrs_pkg::S_SUM_RD:   n_state = phrs_pkg::S_SUM_ACC;
            phrs_pkg::S_SUM_ACC:  n_state = last_elem ? phrs_pkg::S_MEAN_LD : phrs_pkg::S_SUM_RD;
            phrs_pkg::S_MEAN_LD:  n_state = phrs_pkg::S_MEAN_DIV;
            phrs_pkg::S_MEAN_DIV: if (r_cnt == phrs_pkg::DivLast) n_state = phrs_pkg::S_MEAN_FIN;
            phrs_pkg::S_MEAN_FIN: n_state = phrs_pkg::S_VAR_RD;
            phrs_pkg::S_VAR_RD:   n_state = phrs_pkg::S_VAR_MUL;
            phrs_pkg::S_VAR_MUL:  n_state = phrs_pkg::S_VAR_ACC;
            phrs_pkg::S_VAR_ACC:  n_state = last_elem ? phrs_pkg::S_VAR_LD : phrs_pkg::S_VAR_RD;
            phrs_pkg::S_VAR_LD:   n_state = phrs_pkg::S_VAR_DIV;
            phrs_pkg::S_VAR_DIV:  if (r_cnt == phrs_pkg::DivLast) n_state = phrs_pkg::S_VAR_FIN;
            phrs_pkg::S_VAR_FIN:  n_state = phrs_pkg::S_SQRT;
            phrs_pkg::S_SQRT:     if (r_cnt == phrs_pkg::SqrtLast) n_state = phrs_pkg::S_UTIL_RD;
            phrs_pkg::S_UTIL_RD:  n_state = phrs_pkg::S_UTIL_MUL;
            phrs_pkg::S_UTIL_MUL: n_state = phrs_pkg::S_UTIL_T;
            phrs_pkg::S_UTIL_T:   n_state = util_x[68] ? phrs_pkg::S_UTIL_LW : phrs_pkg::S_UTIL_ACC;
            phrs_pkg::S_UTIL_LW:  n_state = phrs_pkg::S_UTIL_LWF;
            phrs_pkg::S_UTIL_LWF: n_state = phrs_pkg::S_UTIL_ACC;
            phrs_pkg::S_UTIL_ACC: n_state = last_elem ? phrs_pkg::S_UTIL_LD : phrs_pkg::S_UTIL_RD;
            phrs_pkg::S_UTIL_LD:  n_state = phrs_pkg::S_UTIL_DIV;
            phrs_pkg::S_UTIL_DIV: if (r_cnt == phrs_pkg::DivLast) n_state = phrs_pkg::S_UTIL_FIN;
            phrs_pkg::S_UTIL_FIN: n_state = phrs_pkg::S_DONE;
            phrs_pkg::S_DONE:     if (out_load) n_state = phrs_pkg::S_IDLE;
            default:              n_state = phrs_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and multiplier operand select
    always_comb begin
        in_ready = (r_state == phrs_pkg::S_IDLE);
        out_load = (r_state == phrs_pkg::S_DONE) && (!r_out_valid || o_result_ch.ready);
        unique case (r_state)
            phrs_pkg::S_VAR_MUL: begin
                mul_a = 36'(dev);
                mul_b = dev;
            end
            phrs_pkg::S_UTIL_MUL: begin
                mul_a = 36'(rd_ret);
                mul_b = 33'(r_scale);
            end
            default: begin
                mul_a = r_t;
                mul_b = $signed({2'b00, r_lw});
            end
        endcase
    end

    assign in_take = i_price_ch.valid && in_ready;

    // config and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phrs_pkg::S_IDLE;
            r_wl        <= phrs_pkg::WinW'(20);
            r_scale     <= 32'sh1000_0000;
            r_offset    <= 32'sd0;
            r_lw        <= 31'h1000_0000;
            r_prev      <= '0;
            r_wp        <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (phrs_pkg::t_reg_idx'(i_cfg_idx))
                    phrs_pkg::REG_WINDOW_LENGTH: r_wl     <= i_cfg_data[phrs_pkg::WinW-1:0];
                    phrs_pkg::REG_RETURN_SCALE:  r_scale  <= $signed(i_cfg_data);
                    phrs_pkg::REG_RETURN_OFFSET: r_offset <= $signed(i_cfg_data);
                    phrs_pkg::REG_LOSS_WEIGHT:   r_lw     <= i_cfg_data[phrs_pkg::LossW-1:0];
                    default: ;
                endcase
            end
            if (r_state == phrs_pkg::S_RET_FIN) begin
                r_prev <= r_price;
                r_wp   <= r_wp + 1'b1;
                r_vld[r_wp + 1'b1] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // return memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == phrs_pkg::S_RET_FIN) begin
            r_mem[r_wp + 1'b1] <= ret_val;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_vld[rd_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            phrs_pkg::S_IDLE: begin
                r_price <= i_price_ch.price;
                r_neg   <= diff_neg;
                r_dvd   <= {12'b0, diff_mag, 28'b0};
                r_dsr   <= i_price_ch.price;
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            phrs_pkg::S_RET_DIV, phrs_pkg::S_MEAN_DIV,
            phrs_pkg::S_VAR_DIV, phrs_pkg::S_UTIL_DIV: begin
                r_rem <= div_ge ? (div_sh - {1'b0, r_dsr}) : div_sh;
                r_dvd <= {r_dvd[phrs_pkg::DivW-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            phrs_pkg::S_RET_FIN: begin
                r_ret  <= ret_val;
                r_flag <= (r_price == '0);
                r_sum  <= '0;
                r_cnt  <= '0;
            end
            phrs_pkg::S_SUM_ACC: begin
                r_sum <= r_sum + 38'(rd_ret);
                r_cnt <= last_elem ? '0 : r_cnt + 1'b1;
            end
            phrs_pkg::S_MEAN_LD: begin
                r_neg <= r_sum[37];
                r_dvd <= phrs_pkg::DivW'(sum_abs);
                r_dsr <= 32'(win_n);
                r_rem <= '0;
                r_cnt <= '0;
            end
            phrs_pkg::S_MEAN_FIN: begin
                r_mean  <= r_neg ? 32'(-r_dvd[31:0]) : $signed(r_dvd[31:0]);
                r_sumsq <= '0;
                r_cnt   <= '0;
            end
            phrs_pkg::S_VAR_ACC: begin
                r_sumsq <= r_sumsq + 71'(r_prod[63:0]);
                r_cnt   <= last_elem ? '0 : r_cnt + 1'b1;
            end
            phrs_pkg::S_VAR_LD: begin
                r_dvd <= phrs_pkg::DivW'(r_sumsq);
                r_dsr <= 32'(win_n);
                r_rem <= '0;
                r_cnt <= '0;
            end
            phrs_pkg::S_VAR_FIN: begin
                r_sv   <= var_val;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            phrs_pkg::S_SQRT: begin
                r_srem <= sq_ge ? 34'(sq_sh - sq_trial) : 34'(sq_sh);
                r_root <= {r_root[30:0], sq_ge};
                r_sv   <= {r_sv[61:0], 2'b00};
                if (r_cnt == phrs_pkg::SqrtLast) begin
                    r_cnt  <= '0;
                    r_usum <= '0;
                    r_vol  <= r_root[30] ? 31'h7FFF_FFFF : {r_root[29:0], sq_ge};
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            phrs_pkg::S_UTIL_T: begin
                // floor of the Q13.56 term to Q13.28 (r_t keeps Q8.28)
                r_term <= util_x[68:28];
                r_t    <= util_x[63:28];
            end
            phrs_pkg::S_UTIL_LWF: begin
                r_term <= r_prod[68:28];
            end
            phrs_pkg::S_UTIL_ACC: begin
                r_usum <= r_usum + 48'(r_term);
                r_cnt  <= last_elem ? '0 : r_cnt + 1'b1;
            end
            phrs_pkg::S_UTIL_LD: begin
                r_neg <= r_usum[47];
                r_dvd <= phrs_pkg::DivW'(usum_abs);
                r_dsr <= 32'(win_n);
                r_rem <= '0;
                r_cnt <= '0;
            end
            phrs_pkg::S_UTIL_FIN: begin
                if (r_neg) begin
                    r_util <= (r_dvd > 72'h8000_0000) ? 32'sh8000_0000 : 32'(-r_dvd[31:0]);
                end else begin
                    r_util <= (r_dvd > 72'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_dvd[31:0]);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_ret  <= r_ret;
            r_out_mean <= r_mean;
            r_out_vol  <= r_vol;
            r_out_util <= r_util;
            r_out_flag <= r_flag;
        end
    end

    assign i_price_ch.ready             = in_ready;
    assign o_result_ch.valid            = r_out_valid;
    assign o_result_ch.newest_return    = r_out_ret;
    assign o_result_ch.mean_return      = r_out_mean;
    assign o_result_ch.volatility       = r_out_vol;
    assign o_result_ch.utility          = r_out_util;
    assign o_result_ch.zero_price_flag  = r_out_flag;

    // a taken word blocks the input until its result is queued
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !in_ready)
        else $error("input taken while busy");

    // write position moves by one per stored return
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phrs_pkg::S_RET_FIN) |=> (r_wp == $past(r_wp) + 1'b1))
        else $error("write position slip");

    // walk index stays inside the window
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phrs_pkg::S_SUM_ACC || r_state == phrs_pkg::S_VAR_ACC ||
         r_state == phrs_pkg::S_UTIL_ACC) |-> (r_cnt < phrs_pkg::CntW'(win_n)))
        else $error("walk index out of window");

    // a pending result stays valid and its newest return is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_ch.ready) |=> $stable(r_out_ret) && r_out_valid)
        else $error("result overwritten");

endmodule
